// File: rtl/slot_slab_binding_allocator_top_defines.svh
// assertion macros shared by the allocator rtl
// no dependencies
`ifndef SLOT_SLAB_BINDING_ALLOCATOR_TOP_DEFINES_SVH
`define SLOT_SLAB_BINDING_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SSBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define SSBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ssba_pkg.sv
// shared constants, codes, structs and helper functions of the allocator
// no dependencies
package ssba_pkg;

	localparam int SLOTS     = 256;
	localparam int SLABS     = 48;
	localparam int MAX_ROWS  = 16;

	localparam int SLOT_W    = 10;
	localparam int FIELD_W   = 16;
	localparam int CNT_W     = 6;
	localparam int SLAB_AW   = 6;
	localparam int PITCH_W   = 7;
	localparam int WIDTH_W   = 9;
	localparam int HEIGHT_W  = 9;
	localparam int ROWS_W    = 5;
	localparam int STATUS_W  = 3;
	localparam int FULL_W    = 6;
	localparam int HALF_W    = 4;

	localparam int SLOT_AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLAB_MAW  = (SLABS > 1) ? $clog2(SLABS) : 1;

	localparam int PITCH_LIMIT  = 64;
	localparam int HEIGHT_LIMIT = 256;
	localparam int SPLIT_MIN    = 8;
	localparam int SPLIT_DIV    = 6;
	// reciprocal of the split divisor in 8 fractional bits, rounded up
	localparam int SPLIT_RECIP  = (256 + SPLIT_DIV - 1) / SPLIT_DIV;

	localparam logic [CNT_W-1:0] SLAB_COUNT_RST = 6'd48;

	localparam logic [1:0] REQ_REGISTER = 2'd0;
	localparam logic [1:0] REQ_LOOKUP   = 2'd1;
	localparam logic [1:0] REQ_CLEAR    = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_HDR_BAD  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NO_FREE  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOT_RES  = 3'd4;

	typedef struct packed {
		logic [PITCH_W-1:0]  pitch;
		logic [HEIGHT_W-1:0] height;
		logic                eight;
		logic [ROWS_W-1:0]   rows;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

	typedef struct packed {
		logic load;
		logic desc_rd;
		logic commit;
	} ssba_cmd_t;

	typedef struct packed {
		logic lookup_hit;
		logic out_free;
	} ssba_sts_t;

	function automatic logic [HALF_W-1:0] split_half(input logic [CNT_W-1:0] c);
		logic [CNT_W+7:0] p;
		p = (CNT_W+8)'(c) * (CNT_W+8)'(SPLIT_RECIP);
		return (c > CNT_W'(SPLIT_MIN)) ? p[HALF_W+7:8] : '0;
	endfunction

	function automatic logic [FULL_W-1:0] split_full(input logic [CNT_W-1:0] c);
		return (c > CNT_W'(SPLIT_MIN)) ? FULL_W'(c - CNT_W'(split_half(c))) : '0;
	endfunction

endpackage

// File: rtl/ssba_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ssba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/ssba_ctrl.sv
// request sequencer of the allocator: accept, map lookup, descriptor read, commit
// depends on ssba_pkg and the assertion macro header
`include "slot_slab_binding_allocator_top_defines.svh"

module ssba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ssba_pkg::ssba_sts_t sts,
	output ssba_pkg::ssba_cmd_t cmd
);
	import ssba_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_DESC
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (sts.lookup_hit) begin
						state_q <= S_DESC;
					end else if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DESC: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_LOOK: begin
				cmd.desc_rd = sts.lookup_hit;
				cmd.commit  = !sts.lookup_hit && sts.out_free;
			end
			S_DESC: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`SSBA_ASSERT_IMP(a_commit_needs_room, clk, arst_n, cmd.commit, sts.out_free, "commit while output full")
	`SSBA_ASSERT_NXT(a_accept_to_look, clk, arst_n, in_valid && in_ready, state_q == S_LOOK, "accept did not start lookup")

endmodule

// File: rtl/ssba_dp.sv
// allocator datapath: request registers, binding map, slab valid bits,
// free slab search, descriptor ram and output register; depends on ssba_pkg, ssba_ram
`include "slot_slab_binding_allocator_top_defines.svh"

module ssba_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ssba_pkg::CNT_W-1:0]          cfg_data,
	input  logic [1:0]                          req_type,
	input  logic [ssba_pkg::SLOT_W-1:0]         slot,
	input  logic [ssba_pkg::FIELD_W-1:0]        pitch_words,
	input  logic [ssba_pkg::FIELD_W-1:0]        height_rows,
	input  logic [1:0]                          bpp_code,
	input  logic                                has_palette,
	input  logic [ssba_pkg::FIELD_W-1:0]        palette_rows,
	input  ssba_pkg::ssba_cmd_t                 cmd,
	output ssba_pkg::ssba_sts_t                 sts,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [ssba_pkg::STATUS_W-1:0]       status,
	output logic [ssba_pkg::SLAB_AW-1:0]        slab_index,
	output logic [ssba_pkg::PITCH_W-1:0]        pitch_out,
	output logic [ssba_pkg::WIDTH_W-1:0]        width_pixels,
	output logic [ssba_pkg::HEIGHT_W-1:0]       height_out,
	output logic                                is_8bpp,
	output logic [ssba_pkg::ROWS_W-1:0]         rows_out,
	output logic [ssba_pkg::FULL_W-1:0]         full_slots,
	output logic [ssba_pkg::HALF_W-1:0]         half_slots
);
	import ssba_pkg::*;

	localparam int GRP  = 8;
	localparam int NGRP = (SLABS + GRP - 1) / GRP;

	logic [CNT_W-1:0]    slab_count_q;
	logic [CNT_W-1:0]    cnt;

	logic [1:0]          req_q;
	logic [SLOT_AW-1:0]  slot_q;
	logic                oor_q;
	logic                hdr_bad_q;
	logic                bound_q;
	desc_t               new_desc_q;
	logic [NGRP-1:0]     grp_hit_q;
	logic [2:0]          grp_idx_q [NGRP];

	logic [SLABS-1:0]    owner_valid_q;
	logic [SLOTS-1:0]    bind_valid_q;

	logic                hdr_bad;
	logic [ROWS_W-1:0]   rows_clamp;
	logic [NGRP*GRP-1:0] avail;
	logic [NGRP-1:0]     grp_hit;
	logic [2:0]          grp_idx [NGRP];

	logic                free_hit;
	logic [SLAB_AW-1:0]  free_idx;
	logic [SLAB_AW-1:0]  bind_slab;
	logic [DESC_W-1:0]   desc_rdata;

	logic [STATUS_W-1:0] res_status;
	logic                res_ok;
	logic [SLAB_AW-1:0]  res_idx;
	logic                claim;
	logic                wr_desc;
	logic                clear_all;
	desc_t               res_desc;

	logic                out_valid_q;
	logic                out_free;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slab_count_q <= SLAB_COUNT_RST;
		end else if (cfg_we) begin
			slab_count_q <= cfg_data;
		end
	end

	assign cnt = ({1'b0, slab_count_q} > (CNT_W+1)'(SLABS)) ? CNT_W'(SLABS) : slab_count_q;

	// header check and request capture
	assign hdr_bad = (bpp_code > 2'd1) || (pitch_words == '0) || (height_rows == '0)
		|| (pitch_words > FIELD_W'(PITCH_LIMIT)) || (height_rows > FIELD_W'(HEIGHT_LIMIT));

	always_comb begin
		rows_clamp = '0;
		if (has_palette) begin
			rows_clamp = (palette_rows > FIELD_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
				: palette_rows[ROWS_W-1:0];
		end
	end

	// first free slab per group of eight
	always_comb begin
		avail = '0;
		for (int i = 0; i < SLABS; i++) begin
			avail[i] = !owner_valid_q[i] && (i < int'(cnt));
		end
		for (int g = 0; g < NGRP; g++) begin
			grp_hit[g] = 1'b0;
			grp_idx[g] = '0;
			for (int j = GRP - 1; j >= 0; j--) begin
				if (avail[g*GRP + j]) begin
					grp_hit[g] = 1'b1;
					grp_idx[g] = 3'(j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q             <= req_type;
			slot_q            <= slot[SLOT_AW-1:0];
			oor_q             <= ({1'b0, slot} >= (SLOT_W+1)'(SLOTS));
			hdr_bad_q         <= hdr_bad;
			bound_q           <= bind_valid_q[slot[SLOT_AW-1:0]];
			new_desc_q.pitch  <= pitch_words[PITCH_W-1:0];
			new_desc_q.height <= height_rows[HEIGHT_W-1:0];
			new_desc_q.eight  <= bpp_code[0];
			new_desc_q.rows   <= rows_clamp;
			grp_hit_q         <= grp_hit;
			for (int g = 0; g < NGRP; g++) begin
				grp_idx_q[g] <= grp_idx[g];
			end
		end
	end

	// combine group results, lowest group wins
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_hit_q[g]) begin
				free_hit = 1'b1;
				free_idx = SLAB_AW'(g*GRP) + SLAB_AW'(grp_idx_q[g]);
			end
		end
	end

	// request decision
	always_comb begin
		res_status = STAT_OK;
		res_ok     = 1'b0;
		res_idx    = bind_slab;
		claim      = 1'b0;
		wr_desc    = 1'b0;
		clear_all  = 1'b0;
		case (req_q)
			REQ_REGISTER: begin
				if (hdr_bad_q) begin
					res_status = STAT_HDR_BAD;
				end else if (oor_q) begin
					res_status = STAT_RANGE;
				end else if (bound_q) begin
					res_ok  = 1'b1;
					wr_desc = cmd.commit;
				end else if (free_hit) begin
					res_ok  = 1'b1;
					res_idx = free_idx;
					claim   = cmd.commit;
					wr_desc = cmd.commit;
				end else begin
					res_status = STAT_NO_FREE;
				end
			end
			REQ_LOOKUP: begin
				if (oor_q) begin
					res_status = STAT_RANGE;
				end else if (!bound_q) begin
					res_status = STAT_NOT_RES;
				end else begin
					res_ok = 1'b1;
				end
			end
			REQ_CLEAR: begin
				clear_all = cmd.commit;
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	assign res_desc = (req_q == REQ_LOOKUP) ? desc_t'(desc_rdata) : new_desc_q;

	assign out_free       = !out_valid_q || out_ready;
	assign sts.out_free   = out_free;
	assign sts.lookup_hit = (req_q == REQ_LOOKUP) && !oor_q && bound_q;

	// binding and ownership valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_valid_q <= '0;
			bind_valid_q  <= '0;
		end else if (clear_all) begin
			owner_valid_q <= '0;
			bind_valid_q  <= '0;
		end else if (claim) begin
			owner_valid_q[free_idx[SLAB_MAW-1:0]] <= 1'b1;
			bind_valid_q[slot_q]                  <= 1'b1;
		end
	end

	ssba_ram #(
		.WIDTH (SLAB_AW),
		.DEPTH (SLOTS)
	) u_bind_ram (
		.clk   (clk),
		.we    (claim),
		.waddr (slot_q),
		.wdata (free_idx),
		.re    (cmd.load),
		.raddr (slot[SLOT_AW-1:0]),
		.rdata (bind_slab)
	);

	ssba_ram #(
		.WIDTH (DESC_W),
		.DEPTH (SLABS)
	) u_desc_ram (
		.clk   (clk),
		.we    (wr_desc),
		.waddr (res_idx[SLAB_MAW-1:0]),
		.wdata (new_desc_q),
		.re    (cmd.desc_rd),
		.raddr (bind_slab[SLAB_MAW-1:0]),
		.rdata (desc_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status     <= res_status;
			full_slots <= split_full(cnt);
			half_slots <= split_half(cnt);
			if (res_ok) begin
				slab_index   <= res_idx;
				pitch_out    <= res_desc.pitch;
				width_pixels <= res_desc.eight ? {1'b0, res_desc.pitch, 1'b0}
					: {res_desc.pitch, 2'b00};
				height_out   <= res_desc.height;
				is_8bpp      <= res_desc.eight;
				rows_out     <= res_desc.rows;
			end else begin
				slab_index   <= '0;
				pitch_out    <= '0;
				width_pixels <= '0;
				height_out   <= '0;
				is_8bpp      <= 1'b0;
				rows_out     <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`SSBA_ASSERT_IMP(a_bind_owner_match, clk, arst_n, 1'b1, $countones(owner_valid_q) == $countones(bind_valid_q), "bound slots and owned slabs differ")
	`SSBA_ASSERT_NXT(a_clear_frees_all, clk, arst_n, clear_all, (owner_valid_q == '0) && (bind_valid_q == '0), "clear left a binding")

endmodule

// File: rtl/slot_slab_binding_allocator_top.sv
// a register, clear or spare request, or a lookup that misses, loads its result from S_LOOK,
// a lookup hit reads the descriptor ram and loads it from S_DESC; both wait for output room
// one request in flight; a new one is taken in the cycle after the result is loaded
// the output register holds a result while the next request is accepted
// the binding map is read at accept and the descriptor ram in S_LOOK, both with registered reads
// reset frees all slabs and slots through valid bits at once; slab count resets to 48
module slot_slab_binding_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ssba_pkg::CNT_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [ssba_pkg::SLOT_W-1:0]   slot,
	input  logic [ssba_pkg::FIELD_W-1:0]  pitch_words,
	input  logic [ssba_pkg::FIELD_W-1:0]  height_rows,
	input  logic [1:0]                    bpp_code,
	input  logic                          has_palette,
	input  logic [ssba_pkg::FIELD_W-1:0]  palette_rows,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ssba_pkg::STATUS_W-1:0] status,
	output logic [ssba_pkg::SLAB_AW-1:0]  slab_index,
	output logic [ssba_pkg::PITCH_W-1:0]  pitch_out,
	output logic [ssba_pkg::WIDTH_W-1:0]  width_pixels,
	output logic [ssba_pkg::HEIGHT_W-1:0] height_out,
	output logic                          is_8bpp,
	output logic [ssba_pkg::ROWS_W-1:0]   rows_out,
	output logic [ssba_pkg::FULL_W-1:0]   full_slots,
	output logic [ssba_pkg::HALF_W-1:0]   half_slots
);
	import ssba_pkg::*;

	ssba_cmd_t cmd;
	ssba_sts_t sts;

	ssba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssba_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.slot         (slot),
		.pitch_words  (pitch_words),
		.height_rows  (height_rows),
		.bpp_code     (bpp_code),
		.has_palette  (has_palette),
		.palette_rows (palette_rows),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.status       (status),
		.slab_index   (slab_index),
		.pitch_out    (pitch_out),
		.width_pixels (width_pixels),
		.height_out   (height_out),
		.is_8bpp      (is_8bpp),
		.rows_out     (rows_out),
		.full_slots   (full_slots),
		.half_slots   (half_slots)
	);

endmodule
